>>> rtl/core/t6msa_pkg.sv
package t6msa_pkg;

  localparam int SqrtStages   = 34;
  localparam int DivStages    = 32;
  localparam int LaneLatency  = 3 + SqrtStages + DivStages + 1;
  localparam int MergeLatency = 2;
  localparam int Latency      = LaneLatency + MergeLatency;
  localparam int NumLanes     = 4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  typedef point_t [2:0] verts_t;
  typedef logic [2:0][31:0] alt3_t;

  typedef struct packed {
    logic signed [31:0] node0_x;
    logic signed [31:0] node0_y;
    logic signed [31:0] node1_x;
    logic signed [31:0] node1_y;
    logic signed [31:0] node2_x;
    logic signed [31:0] node2_y;
    logic signed [31:0] node3_x;
    logic signed [31:0] node3_y;
    logic signed [31:0] node4_x;
    logic signed [31:0] node4_y;
    logic signed [31:0] node5_x;
    logic signed [31:0] node5_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] min_size;
    logic        degenerate;
  } out_item_t;

endpackage

>>> rtl/core/t6msa_sqrt.sv
module t6msa_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [65:0] rad_i,
  output logic [33:0] root_o
);

  logic [67:0] rad_q  [t6msa_pkg::SqrtStages];
  logic [35:0] rem_q  [t6msa_pkg::SqrtStages];
  logic [33:0] root_q [t6msa_pkg::SqrtStages];
  logic [67:0] rad_d  [t6msa_pkg::SqrtStages];
  logic [35:0] rem_d  [t6msa_pkg::SqrtStages];
  logic [33:0] root_d [t6msa_pkg::SqrtStages];

  always_comb begin
    logic [67:0] srad;
    logic [35:0] srem;
    logic [33:0] sroot;
    logic [37:0] r2;
    logic [37:0] trial;
    for (int i = 0; i < t6msa_pkg::SqrtStages; i++) begin
      if (i == 0) begin
        srad  = {2'b00, rad_i};
        srem  = '0;
        sroot = '0;
      end else begin
        srad  = rad_q[i-1];
        srem  = rem_q[i-1];
        sroot = root_q[i-1];
      end
      r2    = {srem, srad[67:66]};
      trial = {2'b00, sroot, 2'b01};
      if (r2 >= trial) begin
        rem_d[i]  = 36'(r2 - trial);
        root_d[i] = {sroot[32:0], 1'b1};
      end else begin
        rem_d[i]  = r2[35:0];
        root_d[i] = {sroot[32:0], 1'b0};
      end
      rad_d[i] = {srad[65:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < t6msa_pkg::SqrtStages; i++) begin
        rad_q[i]  <= rad_d[i];
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
      end
    end
  end

  assign root_o = root_q[t6msa_pkg::SqrtStages-1];

endmodule

>>> rtl/core/t6msa_div.sv
module t6msa_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [65:0] num_i,
  input  logic [33:0] den_i,
  output logic [31:0] quot_o
);

  logic        over_q [t6msa_pkg::DivStages+1];
  logic [33:0] rem_q  [t6msa_pkg::DivStages+1];
  logic [31:0] low_q  [t6msa_pkg::DivStages+1];
  logic [33:0] den_q  [t6msa_pkg::DivStages+1];
  logic [31:0] quo_q  [t6msa_pkg::DivStages+1];
  logic [33:0] rem_d  [t6msa_pkg::DivStages+1];
  logic [31:0] quo_d  [t6msa_pkg::DivStages+1];

  always_comb begin
    logic [34:0] r2;
    rem_d[0] = num_i[65:32];
    quo_d[0] = '0;
    for (int i = 1; i <= t6msa_pkg::DivStages; i++) begin
      r2 = {rem_q[i-1], low_q[i-1][31]};
      if (r2 >= {1'b0, den_q[i-1]}) begin
        rem_d[i] = 34'(r2 - {1'b0, den_q[i-1]});
        quo_d[i] = {quo_q[i-1][30:0], 1'b1};
      end else begin
        rem_d[i] = r2[33:0];
        quo_d[i] = {quo_q[i-1][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      over_q[0] <= num_i >= {den_i, 32'b0};
      low_q[0]  <= num_i[31:0];
      den_q[0]  <= den_i;
      rem_q[0]  <= rem_d[0];
      quo_q[0]  <= quo_d[0];
      for (int i = 1; i <= t6msa_pkg::DivStages; i++) begin
        over_q[i] <= over_q[i-1];
        low_q[i]  <= {low_q[i-1][30:0], 1'b0};
        den_q[i]  <= den_q[i-1];
        rem_q[i]  <= rem_d[i];
        quo_q[i]  <= quo_d[i];
      end
    end
  end

  assign quot_o = over_q[t6msa_pkg::DivStages] ? '1 : quo_q[t6msa_pkg::DivStages];

endmodule

>>> rtl/core/t6msa_lane.sv
module t6msa_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  t6msa_pkg::verts_t vert_i,
  output t6msa_pkg::alt3_t  alt_o,
  output logic              degen_o
);

  logic signed [32:0] ux_q, uy_q, wx_q, wy_q;
  logic signed [32:0] ex_q [3];
  logic signed [32:0] ey_q [3];
  logic signed [65:0] m1_q, m2_q;
  logic signed [65:0] sx_q [3];
  logic signed [65:0] sy_q [3];
  logic [65:0] cabs_q;
  logic        dg_q;
  logic [65:0] s_q [3];
  logic signed [66:0] cr;
  logic [66:0] cd_q [t6msa_pkg::SqrtStages];
  logic        dg2_q [t6msa_pkg::DivStages+1];
  logic [33:0] len [3];

  function automatic logic signed [32:0] sub33(logic signed [31:0] a, logic signed [31:0] b);
    return 33'($signed({a[31], a}) - $signed({b[31], b}));
  endfunction

  assign cr = 67'(m1_q) - 67'(m2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q <= sub33(vert_i[1].x, vert_i[0].x);
      uy_q <= sub33(vert_i[1].y, vert_i[0].y);
      wx_q <= sub33(vert_i[2].x, vert_i[0].x);
      wy_q <= sub33(vert_i[2].y, vert_i[0].y);
      ex_q[0] <= sub33(vert_i[2].x, vert_i[1].x);
      ey_q[0] <= sub33(vert_i[2].y, vert_i[1].y);
      ex_q[1] <= sub33(vert_i[0].x, vert_i[2].x);
      ey_q[1] <= sub33(vert_i[0].y, vert_i[2].y);
      ex_q[2] <= sub33(vert_i[1].x, vert_i[0].x);
      ey_q[2] <= sub33(vert_i[1].y, vert_i[0].y);
      m1_q <= ux_q * wy_q;
      m2_q <= wx_q * uy_q;
      for (int k = 0; k < 3; k++) begin
        sx_q[k] <= ex_q[k] * ex_q[k];
        sy_q[k] <= ey_q[k] * ey_q[k];
        s_q[k]  <= 66'(unsigned'(sx_q[k])) + 66'(unsigned'(sy_q[k]));
      end
      cabs_q <= cr[66] ? 66'(-cr) : cr[65:0];
      dg_q   <= cr == '0;
      cd_q[0] <= {dg_q, cabs_q};
      for (int i = 1; i < t6msa_pkg::SqrtStages; i++) begin
        cd_q[i] <= cd_q[i-1];
      end
      dg2_q[0] <= cd_q[t6msa_pkg::SqrtStages-1][66];
      for (int i = 1; i <= t6msa_pkg::DivStages; i++) begin
        dg2_q[i] <= dg2_q[i-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_edge
    t6msa_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .rad_i  (s_q[k]),
      .root_o (len[k])
    );
    t6msa_div u_div (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .num_i  (cd_q[t6msa_pkg::SqrtStages-1][65:0]),
      .den_i  (len[k]),
      .quot_o (alt_o[k])
    );
  end

  assign degen_o = dg2_q[t6msa_pkg::DivStages];

endmodule

>>> rtl/core/t6msa_merge.sv
module t6msa_merge (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  t6msa_pkg::alt3_t [t6msa_pkg::NumLanes-1:0] alt_i,
  input  logic [t6msa_pkg::NumLanes-1:0]          degen_i,
  output t6msa_pkg::out_item_t                    item_o
);

  logic [31:0] m_q [t6msa_pkg::NumLanes];
  logic [31:0] m_d [t6msa_pkg::NumLanes];
  logic        dg_q;
  logic [31:0] best;

  always_comb begin
    logic [31:0] a;
    for (int l = 0; l < t6msa_pkg::NumLanes; l++) begin
      a = (alt_i[l][0] < alt_i[l][1]) ? alt_i[l][0] : alt_i[l][1];
      m_d[l] = (alt_i[l][2] < a) ? alt_i[l][2] : a;
    end
    best = '1;
    for (int l = 0; l < t6msa_pkg::NumLanes; l++) begin
      if (m_q[l] < best) begin
        best = m_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < t6msa_pkg::NumLanes; l++) begin
        m_q[l] <= degen_i[l] ? '1 : m_d[l];
      end
      dg_q              <= |degen_i;
      item_o.degenerate <= dg_q;
      item_o.min_size   <= dg_q ? '0 : best;
    end
  end

endmodule

>>> rtl/core/t6_min_subtriangle_altitude.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | in_item_i  (six node coordinates)
// out     | output    | out_valid_o/out_ready_i | out_item_o (min_size, degenerate)
//
// One item is accepted per cycle while the pipeline is not stalled.
// Most of the latency comes from the 34-stage square root and 33-stage divider in each lane.
// Reset clears only the valid bits of the pipeline.
// When the output holds a result that is not taken, the whole pipeline stalls.
module t6_min_subtriangle_altitude (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  t6msa_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output t6msa_pkg::out_item_t out_item_o
);

  logic [t6msa_pkg::Latency-1:0] vld_q;
  logic en;
  t6msa_pkg::point_t pt [6];
  t6msa_pkg::verts_t [t6msa_pkg::NumLanes-1:0] verts;
  t6msa_pkg::alt3_t [t6msa_pkg::NumLanes-1:0] alt;
  logic [t6msa_pkg::NumLanes-1:0] degen;

  assign en          = !vld_q[t6msa_pkg::Latency-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[t6msa_pkg::Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[t6msa_pkg::Latency-2:0], in_valid_i};
    end
  end

  always_comb begin
    pt[0] = '{x: in_item_i.node0_x, y: in_item_i.node0_y};
    pt[1] = '{x: in_item_i.node1_x, y: in_item_i.node1_y};
    pt[2] = '{x: in_item_i.node2_x, y: in_item_i.node2_y};
    pt[3] = '{x: in_item_i.node3_x, y: in_item_i.node3_y};
    pt[4] = '{x: in_item_i.node4_x, y: in_item_i.node4_y};
    pt[5] = '{x: in_item_i.node5_x, y: in_item_i.node5_y};
    verts[0] = {pt[5], pt[2], pt[0]};
    verts[1] = {pt[2], pt[1], pt[0]};
    verts[2] = {pt[4], pt[2], pt[1]};
    verts[3] = {pt[3], pt[1], pt[0]};
  end

  for (genvar l = 0; l < t6msa_pkg::NumLanes; l++) begin : g_lane
    t6msa_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .vert_i  (verts[l]),
      .alt_o   (alt[l]),
      .degen_o (degen[l])
    );
  end

  t6msa_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .alt_i   (alt),
    .degen_i (degen),
    .item_o  (out_item_o)
  );

endmodule
